/* rtl/core/ln1p_pkg.sv */
// Shared types and fixed widths for the ln(1+x) series unit
package ln1p_pkg;

  // Field and datapath widths
  localparam int unsigned X_W    = 32;  // x and running power
  localparam int unsigned RES_W  = 40;  // saturating accumulator / result
  localparam int unsigned TERM_W = 13;  // term count and term index
  localparam int unsigned MAG_W  = 31;  // |power| <= 2^30 fits in 31 bits
  localparam int unsigned DCNT_W = 5;   // divider step counter (MAG_W steps)

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DINIT,
    ST_DIV,
    ST_ACC,
    ST_MUL,
    ST_FINISH
  } ln1p_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture x, clear sum, n = 1
    logic div_init;  // load |power| into divider
    logic div_step;  // one restoring division step
    logic acc;       // add or subtract quotient into sum
    logic mul;       // power = power * x, n = n + 1
    logic out_load;  // move result into output register
  } ln1p_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic range_err;   // x outside (-1, 1]
    logic terms_zero;  // no terms to sum
    logic div_last;    // final division step this cycle
    logic last_term;   // current index equals term count
  } ln1p_sts_t;

endpackage

/* rtl/core/ln1p_in_if.sv */
// Input channel: one x value per beat
interface ln1p_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ln1p_pkg::X_W-1:0]     x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

/* rtl/core/ln1p_out_if.sv */
// Output channel: one series sum and error flag per beat
interface ln1p_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ln1p_pkg::RES_W-1:0]   log_result;
  logic                                range_error;

  modport source (output valid, output log_result, output range_error, input ready);
  modport sink   (input valid, input log_result, input range_error, output ready);
endinterface

/* rtl/core/ln1p_datapath.sv */
// Power register, multiplier, restoring divider and saturating accumulator
module ln1p_datapath #(
  parameter int MAX_TERMS = 4096,
  parameter int FRAC_BITS = 30
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ln1p_pkg::TERM_W-1:0]          cfg_wdata_i,
  input  logic signed [ln1p_pkg::X_W-1:0]      x_value_i,
  input  ln1p_pkg::ln1p_cmd_t                  cmd_i,
  output ln1p_pkg::ln1p_sts_t                  sts_o,
  output logic signed [ln1p_pkg::RES_W-1:0]    log_result_o,
  output logic                                 range_error_o
);
  import ln1p_pkg::*;

  localparam int TermMax = (1 << TERM_W) - 1;
  localparam int TermCap = (MAX_TERMS > TermMax) ? TermMax : MAX_TERMS;
  localparam logic [TERM_W-1:0] TermCapV = TERM_W'(TermCap);
  localparam logic [TERM_W-1:0] TermReset = TERM_W'(16);
  localparam logic signed [X_W:0] OneFx = (X_W+1)'(1) <<< FRAC_BITS;
  localparam logic [DCNT_W-1:0] DivSteps = DCNT_W'(MAG_W - 1);

  logic [TERM_W-1:0]       num_terms_q;
  logic signed [X_W-1:0]   x_q, power_q, power_d;
  logic [TERM_W-1:0]       n_q, terms_q;
  logic                    err_q;
  logic signed [RES_W-1:0] sum_q, sum_d;
  logic [TERM_W:0]         rem_q, rem_d;
  logic [MAG_W-1:0]        dq_q, dq_d;
  logic [DCNT_W-1:0]       cnt_q;
  logic                    neg_q;
  logic signed [RES_W-1:0] log_q;
  logic                    rerr_q;

  logic signed [X_W:0]       x_ext;
  logic                      x_err;
  logic [TERM_W-1:0]         terms_clamped;
  logic signed [2*X_W-1:0]   prod;
  logic signed [2*X_W-1:0]   prod_sh;
  logic [X_W-1:0]            power_abs;
  logic [TERM_W:0]           trial;
  logic                      q_bit;
  logic signed [RES_W:0]     addend, sum_wide;

  // Range check and term clamp on the incoming item
  assign x_ext = {x_value_i[X_W-1], x_value_i};
  assign x_err = (x_ext <= -OneFx) || (x_ext > OneFx);
  assign terms_clamped = (num_terms_q > TermCapV) ? TermCapV : num_terms_q;

  // Power update: floor(power * x / 2^FRAC_BITS)
  assign prod    = power_q * x_q;
  assign prod_sh = prod >>> FRAC_BITS;
  assign power_d = prod_sh[X_W-1:0];

  assign power_abs = power_q[X_W-1] ? (~power_q + X_W'(1)) : power_q;

  // One restoring division step
  always_comb begin
    trial = {rem_q[TERM_W-1:0], dq_q[MAG_W-1]};
    q_bit = (trial >= {1'b0, n_q});
    rem_d = q_bit ? (trial - {1'b0, n_q}) : trial;
    dq_d  = {dq_q[MAG_W-2:0], q_bit};
  end

  // Signed term and saturating sum
  always_comb begin
    addend   = neg_q ? -$signed({{(RES_W+1-MAG_W){1'b0}}, dq_q})
                     :  $signed({{(RES_W+1-MAG_W){1'b0}}, dq_q});
    sum_wide = {sum_q[RES_W-1], sum_q} + addend;
    if (sum_wide[RES_W] != sum_wide[RES_W-1]) begin
      sum_d = sum_wide[RES_W] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else begin
      sum_d = sum_wide[RES_W-1:0];
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_terms_q <= TermReset;
    end else if (cfg_we_i) begin
      num_terms_q <= cfg_wdata_i;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= x_value_i;
      power_q <= x_value_i;
      n_q     <= TERM_W'(1);
      terms_q <= terms_clamped;
      err_q   <= x_err;
      sum_q   <= '0;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      dq_q  <= power_abs[MAG_W-1:0];
      cnt_q <= DivSteps;
      neg_q <= power_q[X_W-1] ^ ~n_q[0];
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
      cnt_q <= cnt_q - DCNT_W'(1);
    end
    if (cmd_i.acc) begin
      sum_q <= sum_d;
    end
    if (cmd_i.mul) begin
      power_q <= power_d;
      n_q     <= n_q + TERM_W'(1);
    end
    if (cmd_i.out_load) begin
      log_q  <= err_q ? '0 : sum_q;
      rerr_q <= err_q;
    end
  end

  assign sts_o.range_err  = err_q;
  assign sts_o.terms_zero = (terms_q == '0);
  assign sts_o.div_last   = (cnt_q == '0);
  assign sts_o.last_term  = (n_q == terms_q);

  assign log_result_o  = log_q;
  assign range_error_o = rerr_q;

`ifndef NO_ASSERTIONS
  // Running power stays within one in magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |=> ($signed({power_q[X_W-1], power_q}) <= OneFx) &&
                  ($signed({power_q[X_W-1], power_q}) >= -OneFx))
    else $error("power left [-1, 1]");
  // Partial remainder always below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (rem_q < {1'b0, n_q}))
    else $error("divider remainder not reduced");
`endif

endmodule

/* rtl/core/ln1p_ctrl.sv */
// Sequencer: per term, divider load, division steps, accumulate, and power update before the next term
module ln1p_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ln1p_pkg::ln1p_sts_t  sts_i,
  output ln1p_pkg::ln1p_cmd_t  cmd_o
);
  import ln1p_pkg::*;

  ln1p_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        if (sts_i.range_err || sts_i.terms_zero) state_d = ST_FINISH;
        else state_d = ST_DINIT;
      end
      ST_DINIT:  state_d = ST_DIV;
      ST_DIV:    if (sts_i.div_last) state_d = ST_ACC;
      ST_ACC: begin
        if (sts_i.last_term) state_d = ST_FINISH;
        else state_d = ST_MUL;
      end
      ST_MUL:    state_d = ST_DINIT;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK:  ;
      ST_DINIT:  cmd_o.div_init = 1'b1;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_ACC:    cmd_o.acc = 1'b1;
      ST_MUL:    cmd_o.mul = 1'b1;
      ST_FINISH: cmd_o.out_load = out_free;
      default:   ;
    endcase
  end

  // Output register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // A held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_valid_q) && !$past(cmd_o.out_load))
    else $error("pending result overwritten");
  // An accepted beat starts the range check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_CHECK))
    else $error("accepted beat not processed");
  // The final division step is followed by accumulation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && sts_i.div_last) |=> (state_q == ST_ACC))
    else $error("division did not end in accumulate");
`endif

endmodule

/* rtl/core/ln1p_taylor_series_unit.sv */
// ln(1+x) truncated Taylor series, one x per evaluation.
// Per term of the clamped term count: a divider load, 31 restoring divide steps, an accumulate
// and, for every term but the last, a multiply.
// Out-of-range x or zero terms: the sequencer goes from the range check straight to the result.
// One x at a time: a new beat is taken only after the last result is loaded; a held result stalls input.
// Reset (async, active low): sequencer idle, output empty, num_terms = 16.
module ln1p_taylor_series_unit #(
  parameter int MAX_TERMS = 4096,
  parameter int FRAC_BITS = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ln1p_pkg::TERM_W-1:0]   cfg_wdata_i,
  ln1p_in_if.sink                       in_ch,
  ln1p_out_if.source                    out_ch
);
  import ln1p_pkg::*;

  ln1p_cmd_t cmd;
  ln1p_sts_t sts;

  // Sequencer
  ln1p_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic
  ln1p_datapath #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .x_value_i     (in_ch.x_value),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .log_result_o  (out_ch.log_result),
    .range_error_o (out_ch.range_error)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import ln1p_pkg::*;

  localparam int     MAX_TERMS   = 4096;
  localparam int     FRAC_BITS   = 30;
  localparam longint ONE_FX      = 64'sd1 <<< FRAC_BITS;
  localparam longint SUM_HI      = (64'sd1 <<< (RES_W - 1)) - 1;
  localparam longint SUM_LO      = -SUM_HI - 1;
  localparam int     CYCLE_LIMIT = 6_000_000;
  localparam int     RAND_PHASES = 10;
  localparam int     PHASE_BEATS = 100;
  localparam int     LONG_HOLD   = 400;
  localparam int     N_DIR       = 25;

  typedef struct packed {
    logic signed [RES_W-1:0] log_result;
    logic                    range_error;
  } ln1p_res_t;

  typedef enum logic [1:0] {
    ROW_X,        // x beat, result from the predictor
    ROW_X_TYPED,  // x beat, result given in the row
    ROW_CFG       // write num_terms
  } row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [X_W-1:0]  val;
    ln1p_res_t       want;
  } stim_row_t;

  // Directed table; default of 16 terms until the first write
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    '{ROW_X_TYPED, 32'h0000_0000, '{40'sd0, 1'b0}},  // zero straight after reset
    '{ROW_X,       32'h4000_0000, '0},               // x = +1
    '{ROW_X,       32'hC000_0001, '0},               // just above -1
    '{ROW_X_TYPED, 32'hC000_0000, '{40'sd0, 1'b1}},  // x = -1 is out of range
    '{ROW_X_TYPED, 32'h4000_0001, '{40'sd0, 1'b1}},  // just above +1
    '{ROW_X_TYPED, 32'h7FFF_FFFF, '{40'sd0, 1'b1}},
    '{ROW_X_TYPED, 32'h8000_0000, '{40'sd0, 1'b1}},
    '{ROW_X,       32'h0000_0001, '0},
    '{ROW_X,       32'hFFFF_FFFF, '0},
    '{ROW_X,       32'h2000_0000, '0},
    '{ROW_X,       32'hE000_0000, '0},
    '{ROW_X,       32'h3FFF_FFFF, '0},
    '{ROW_X,       32'h2AAA_AAAA, '0},
    '{ROW_X,       32'hD555_5556, '0},
    '{ROW_CFG,     32'd0,         '0},               // zero terms
    '{ROW_X_TYPED, 32'h2000_0000, '{40'sd0, 1'b0}},
    '{ROW_X_TYPED, 32'h8000_0000, '{40'sd0, 1'b1}},  // error still flagged
    '{ROW_CFG,     32'd1,         '0},               // single term gives x back
    '{ROW_X_TYPED, 32'h4000_0000, '{40'sd1073741824, 1'b0}},
    '{ROW_X_TYPED, 32'hC000_0001, '{-40'sd1073741823, 1'b0}},
    '{ROW_CFG,     32'd8191,      '0},               // above the clamp
    '{ROW_X,       32'h4000_0000, '0},
    '{ROW_CFG,     32'd4096,      '0},               // exactly at the clamp
    '{ROW_X,       32'hC000_0001, '0},
    '{ROW_X_TYPED, 32'h4000_0001, '{40'sd0, 1'b1}}
  };

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i;
  logic [TERM_W-1:0] cfg_wdata_i;

  ln1p_in_if  x_ch ();
  ln1p_out_if r_ch ();

  ln1p_taylor_series_unit #(
    .MAX_TERMS(MAX_TERMS),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (x_ch),
    .out_ch     (r_ch)
  );

  ln1p_res_t         sum_q [$];      // expected sums, oldest first
  logic [TERM_W-1:0] terms_shadow = TERM_W'(16);
  int unsigned       err_cnt      = 0;
  int unsigned       cycle_cnt    = 0;
  bit                no_idle      = 1'b0;
  bit                hold_req     = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Truncated series for ln(1+x), fixed point, saturating
  function automatic ln1p_res_t eval_ln1p(logic signed [X_W-1:0] x,
                                          logic [TERM_W-1:0] terms);
    ln1p_res_t res;
    longint    xs;
    longint    pw;
    longint    t;
    longint    acc;
    int        cnt;
    res = '0;
    xs  = x;
    if (xs <= -ONE_FX || xs > ONE_FX) begin
      res.range_error = 1'b1;
      return res;
    end
    cnt = (terms > MAX_TERMS) ? MAX_TERMS : int'(terms);
    acc = 0;
    pw  = xs;
    for (int n = 1; n <= cnt; n++) begin
      if (n > 1) pw = (pw * xs) >>> FRAC_BITS;
      t   = pw / n;  // truncates toward zero
      acc = (n % 2 == 1) ? acc + t : acc - t;
      if (acc > SUM_HI) acc = SUM_HI;
      else if (acc < SUM_LO) acc = SUM_LO;
    end
    res.log_result = acc[RES_W-1:0];
    return res;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 150);
  endfunction

  // Mostly in range, with edges, tiny values and raw noise
  function automatic logic [X_W-1:0] rand_x();
    int r;
    r = $urandom_range(0, 15);
    if (r < 10) return $urandom_range(1, 32'h8000_0000) - 32'h4000_0000;
    if (r == 10) return $urandom_range(0, 255) - 32'd128;
    if (r == 11) begin
      case ($urandom_range(0, 3))
        0:       return 32'h4000_0000;
        1:       return 32'hC000_0001;
        2:       return 32'h0000_0000;
        default: return 32'h3FFF_FFFF;
      endcase
    end
    if (r == 12) return $urandom_range(0, 1) ? 32'hC000_0000 : 32'h4000_0001;
    if (r < 15) return $urandom();
    return $urandom_range(0, 1) ? 32'h4000_0000 - $urandom_range(0, 1023)
                                : 32'hC000_0000 + $urandom_range(1, 1024);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // One x beat; expectation queued at the accepting edge
  task automatic send_x(logic [X_W-1:0] val, bit typed, ln1p_res_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      x_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    x_ch.valid   <= 1'b1;
    x_ch.x_value <= val;
    do @(posedge clk_i); while (!x_ch.ready);
    sum_q.push_back(typed ? want : eval_ln1p(val, terms_shadow));
  endtask

  // Stop offering and wait for every outstanding sum
  task automatic drain();
    x_ch.valid <= 1'b0;
    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_terms(logic [TERM_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    terms_shadow = v;
  endtask

  // Result side: random stalls, plus the long hold on request
  initial begin
    int stall_left;
    int hold_left;
    r_ch.ready = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        r_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        r_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        r_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare each result beat with the oldest expected sum
  always @(posedge clk_i) begin
    ln1p_res_t want;
    if (rst_ni && r_ch.valid && r_ch.ready) begin
      if (sum_q.size() == 0) begin
        report_mismatch($sformatf("result beat %0d/%0b with nothing expected",
                                  r_ch.log_result, r_ch.range_error));
      end else begin
        want = sum_q.pop_front();
        if (r_ch.log_result !== want.log_result)
          report_mismatch($sformatf("log_result got %0d expected %0d",
                                    r_ch.log_result, want.log_result));
        if (r_ch.range_error !== want.range_error)
          report_mismatch($sformatf("range_error got %0b expected %0b",
                                    r_ch.range_error, want.range_error));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** ln1p_taylor_series_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int terms;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    x_ch.valid   = 1'b0;
    x_ch.x_value = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (DIR_ROWS[i]) begin
      case (DIR_ROWS[i].kind)
        ROW_CFG:     write_terms(DIR_ROWS[i].val[TERM_W-1:0]);
        ROW_X_TYPED: send_x(DIR_ROWS[i].val, 1'b1, DIR_ROWS[i].want);
        default:     send_x(DIR_ROWS[i].val, 1'b0, '0);
      endcase
    end

    // Back pressure: hold results off while beats keep coming
    write_terms(TERM_W'(1));
    @(negedge clk_i);
    hold_req = 1'b1;
    no_idle  = 1'b1;
    @(posedge clk_i);
    repeat (24) send_x(rand_x(), 1'b0, '0);
    no_idle  = 1'b0;

    // Random phases, small term counts mostly
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:               terms = 0;
        1:               terms = 1;
        2:               terms = 2;
        3:               terms = 3;
        RAND_PHASES - 1: terms = 31;
        default:         terms = $urandom_range(4, 24);
      endcase
      write_terms(terms[TERM_W-1:0]);
      no_idle = (ph % 4 == 3);
      repeat (PHASE_BEATS) send_x(rand_x(), 1'b0, '0);
      no_idle = 1'b0;
    end

    // Let stragglers surface, then report
    x_ch.valid <= 1'b0;
    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (34 * terms_shadow + 10) @(posedge clk_i);
    if (err_cnt == 0 && sum_q.size() == 0) begin
      $display("** ln1p_taylor_series_unit: PASSED **");
    end else begin
      $display("** ln1p_taylor_series_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ln1p_pkg.sv
rtl/core/ln1p_in_if.sv
rtl/core/ln1p_out_if.sv
rtl/core/ln1p_datapath.sv
rtl/core/ln1p_ctrl.sv
rtl/core/ln1p_taylor_series_unit.sv
test/tb_top.sv
